### rtl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;

    // Command codes carried in the operation field.
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_WRITE     = 3'd3;
    localparam logic [2:0] OP_WAITACK   = 3'd4;
    localparam logic [2:0] OP_READ_ACK  = 3'd5;
    localparam logic [2:0] OP_READ_NACK = 3'd6;

    // Sequence phases within a command.
    localparam logic [2:0] PH_FIRST    = 3'd0;
    localparam logic [2:0] PH_LOW      = 3'd1;
    localparam logic [2:0] PH_HIGH     = 3'd2;
    localparam logic [2:0] PH_TAIL     = 3'd3;
    localparam logic [2:0] PH_ACK_HIGH = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_DELAY_TICKS    = 2'd0;
    localparam logic [1:0] REG_ACK_POLL_LIMIT = 2'd1;

    localparam logic [15:0] DELAY_TICKS_RESET    = 16'd125;
    localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd255;

    typedef struct packed {
        logic [15:0] delay_ticks;
        logic [7:0]  ack_poll_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  active_command;
        logic [2:0]  phase;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [15:0] delay_count;
        logic [7:0]  poll_count;
        logic        scl;
        logic        drive;
        logic        sda;
        logic        ack_flag;
        logic [7:0]  read_latch;
    } seq_state_t;

endpackage

### rtl/i2cm_cmd_if.sv
`timescale 1ns / 1ps

interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, output operation, output write_data, output sda_in,
                    input ready);
    modport sink (input valid, input operation, input write_data, input sda_in,
                  output ready);
endinterface

### rtl/i2cm_res_if.sv
`timescale 1ns / 1ps

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_ok;
    logic       rejected;

    modport source (output valid, output scl_level, output sda_drive, output sda_level,
                    output busy_res, output done_res, output read_data, output ack_ok,
                    output rejected, input ready);
    modport sink (input valid, input scl_level, input sda_drive, input sda_level,
                  input busy_res, input done_res, input read_data, input ack_ok,
                  input rejected, output ready);
endinterface

### rtl/i2cm_cfg_if.sv
`timescale 1ns / 1ps

interface i2cm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/i2cm_cfg_regs.sv
`timescale 1ns / 1ps

module i2cm_cfg_regs
    import i2cm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    i2cm_cfg_if.sink     cfg,
    output cfg_t         cfg_values
);

    logic [15:0] delay_ticks_reg;
    logic [7:0]  ack_poll_limit_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg    <= DELAY_TICKS_RESET;
            ack_poll_limit_reg <= ACK_POLL_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DELAY_TICKS:    delay_ticks_reg <= cfg.data;
                REG_ACK_POLL_LIMIT: ack_poll_limit_reg <= cfg.data[7:0];
                default:            ;
            endcase
        end
    end

    assign cfg_values.delay_ticks    = delay_ticks_reg;
    assign cfg_values.ack_poll_limit = ack_poll_limit_reg;

endmodule

### rtl/i2cm_step.sv
`timescale 1ns / 1ps

module i2cm_step
    import i2cm_pkg::*;
(
    input  seq_state_t  cur,
    input  cfg_t        cfg_values,
    input  logic [2:0]  operation,
    input  logic [7:0]  write_data,
    input  logic        sda_in,
    output seq_state_t  nxt,
    output logic        done,
    output logic        rejected
);

    logic [15:0] load_ticks;
    logic [7:0]  poll_limit;
    logic [7:0]  poll_inc;
    logic [3:0]  bit_inc;

    assign load_ticks = (cfg_values.delay_ticks == 16'd0) ? 16'd1 : cfg_values.delay_ticks;
    assign poll_limit = (cfg_values.ack_poll_limit == 8'd0) ? 8'd1
                                                            : cfg_values.ack_poll_limit;
    assign poll_inc   = cur.poll_count + 8'd1;
    assign bit_inc    = cur.bit_count + 4'd1;

    always_comb
    begin
        nxt      = cur;
        done     = 1'b0;
        rejected = 1'b0;

        if (cur.active_command == OP_TICK)
        begin
            if (operation >= OP_START && operation <= OP_READ_NACK)
            begin
                nxt.bit_count   = 4'd0;
                nxt.poll_count  = 8'd0;
                nxt.delay_count = load_ticks;
                nxt.phase       = PH_FIRST;
                nxt.active_command = operation;
                case (operation)
                    OP_START:
                    begin
                        nxt.scl   = 1'b1;
                        nxt.drive = 1'b1;
                        nxt.sda   = 1'b1;
                    end
                    OP_STOP:
                    begin
                        nxt.scl   = 1'b0;
                        nxt.drive = 1'b1;
                        nxt.sda   = 1'b0;
                    end
                    OP_WRITE:
                    begin
                        nxt.shift_byte = write_data;
                        nxt.scl        = 1'b0;
                        nxt.drive      = 1'b1;
                        nxt.sda        = write_data[7];
                        nxt.phase      = PH_LOW;
                    end
                    OP_WAITACK:
                    begin
                        nxt.ack_flag = 1'b0;
                        nxt.drive    = 1'b0;
                        nxt.sda      = 1'b1;
                    end
                    default:
                    begin
                        nxt.shift_byte = 8'd0;
                        nxt.scl        = 1'b0;
                        nxt.drive      = 1'b0;
                        nxt.phase      = PH_LOW;
                    end
                endcase
            end
        end
        else
        begin
            rejected = (operation != OP_TICK);

            if (cur.active_command == OP_WAITACK && cur.phase == PH_HIGH)
            begin
                // Polling SDA once per tick while SCL is high.
                if (!sda_in)
                begin
                    nxt.ack_flag       = 1'b1;
                    nxt.sda            = 1'b0;
                    nxt.active_command = OP_TICK;
                    nxt.phase          = PH_FIRST;
                    done               = 1'b1;
                end
                else
                begin
                    nxt.poll_count = poll_inc;
                    if (poll_inc >= poll_limit)
                    begin
                        nxt.ack_flag       = 1'b0;
                        nxt.active_command = OP_STOP;
                        nxt.scl            = 1'b0;
                        nxt.drive          = 1'b1;
                        nxt.sda            = 1'b0;
                        nxt.delay_count    = load_ticks;
                        nxt.phase          = PH_FIRST;
                    end
                end
            end
            else if (cur.delay_count > 16'd1)
            begin
                nxt.delay_count = cur.delay_count - 16'd1;
            end
            else
            begin
                nxt.delay_count = 16'd0;
                case (cur.active_command)
                    OP_START:
                    begin
                        if (cur.phase == PH_FIRST)
                        begin
                            nxt.sda         = 1'b0;
                            nxt.delay_count = load_ticks;
                            nxt.phase       = PH_LOW;
                        end
                        else
                        begin
                            nxt.scl            = 1'b0;
                            nxt.active_command = OP_TICK;
                            nxt.phase          = PH_FIRST;
                            done               = 1'b1;
                        end
                    end
                    OP_STOP:
                    begin
                        if (cur.phase == PH_FIRST)
                        begin
                            nxt.scl         = 1'b1;
                            nxt.delay_count = load_ticks;
                            nxt.phase       = PH_LOW;
                        end
                        else
                        begin
                            nxt.sda            = 1'b1;
                            nxt.active_command = OP_TICK;
                            nxt.phase          = PH_FIRST;
                            done               = 1'b1;
                        end
                    end
                    OP_WAITACK:
                    begin
                        nxt.scl        = 1'b1;
                        nxt.poll_count = 8'd0;
                        nxt.phase      = PH_HIGH;
                    end
                    OP_WRITE:
                    begin
                        if (cur.phase == PH_LOW)
                        begin
                            nxt.shift_byte  = {cur.shift_byte[6:0], 1'b0};
                            nxt.scl         = 1'b1;
                            nxt.delay_count = load_ticks;
                            nxt.phase       = PH_HIGH;
                        end
                        else if (cur.phase == PH_HIGH)
                        begin
                            nxt.scl         = 1'b0;
                            nxt.delay_count = load_ticks;
                            nxt.phase       = PH_TAIL;
                        end
                        else
                        begin
                            nxt.bit_count = bit_inc;
                            if (bit_inc >= 4'(BITS_PER_BYTE))
                            begin
                                nxt.active_command = OP_TICK;
                                nxt.phase          = PH_FIRST;
                                done               = 1'b1;
                            end
                            else
                            begin
                                nxt.sda         = cur.shift_byte[7];
                                nxt.delay_count = load_ticks;
                                nxt.phase       = PH_LOW;
                            end
                        end
                    end
                    default:
                    begin
                        // Read with ACK or NACK: sample on the rising SCL edge.
                        if (cur.phase == PH_LOW)
                        begin
                            nxt.scl         = 1'b1;
                            nxt.shift_byte  = {cur.shift_byte[6:0], sda_in};
                            nxt.delay_count = load_ticks;
                            nxt.phase       = PH_HIGH;
                        end
                        else if (cur.phase == PH_HIGH)
                        begin
                            nxt.bit_count   = bit_inc;
                            nxt.delay_count = load_ticks;
                            if (bit_inc < 4'(BITS_PER_BYTE))
                            begin
                                nxt.scl   = 1'b0;
                                nxt.phase = PH_LOW;
                            end
                            else
                            begin
                                nxt.read_latch = cur.shift_byte;
                                nxt.scl        = 1'b0;
                                nxt.drive      = 1'b1;
                                nxt.sda        = (cur.active_command == OP_READ_ACK) ? 1'b0
                                                                                      : 1'b1;
                                nxt.phase      = PH_TAIL;
                            end
                        end
                        else if (cur.phase == PH_TAIL)
                        begin
                            nxt.scl         = 1'b1;
                            nxt.delay_count = load_ticks;
                            nxt.phase       = PH_ACK_HIGH;
                        end
                        else
                        begin
                            nxt.scl            = 1'b0;
                            nxt.active_command = OP_TICK;
                            nxt.phase          = PH_FIRST;
                            done               = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

endmodule

### rtl/i2c_master_bit_sequencer_core.sv
`timescale 1ns / 1ps

// Channel | Role   | Payload
// cmd     | sink   | operation[2:0], write_data[7:0], sda_in
// res     | source | scl_level, sda_drive, sda_level, busy_res, done_res,
//         |        | read_data[7:0], ack_ok, rejected
// cfg     | sink   | index[1:0], data[15:0] (0: delay_ticks, 1: ack_poll_limit)
//
// Every command transaction yields exactly one result transaction: the item is held in
// the input register, then passes through the step logic into the result register.
// One transaction per cycle is sustained unless res stalls. The sequencer state updates
// when an item leaves the input register, so back-to-back items chain correctly.
// A stalled result holds the input register; cmd.ready drops only when both are full.
// Reset brings the sequencer idle with SCL high and SDA driven high; cfg is always ready.

module i2c_master_bit_sequencer_core
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    i2cm_cmd_if.sink   cmd,
    i2cm_res_if.source res,
    i2cm_cfg_if.sink   cfg
);

    cfg_t        cfg_values;

    logic        in_valid_reg;
    logic [2:0]  in_operation_reg;
    logic [7:0]  in_write_data_reg;
    logic        in_sda_reg;

    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic        step_done;
    logic        step_rejected;

    logic        out_valid_reg;
    logic        out_busy_reg;
    logic        out_done_reg;
    logic        out_rejected_reg;

    logic        out_free;
    logic        advance;

    i2cm_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    i2cm_step u_step (
        .cur        (state_reg),
        .cfg_values (cfg_values),
        .operation  (in_operation_reg),
        .write_data (in_write_data_reg),
        .sda_in     (in_sda_reg),
        .nxt        (state_next),
        .done       (step_done),
        .rejected   (step_rejected)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign advance   = in_valid_reg && out_free;
    assign cmd.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_operation_reg  <= cmd.operation;
            in_write_data_reg <= cmd.write_data;
            in_sda_reg        <= cmd.sda_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{active_command: OP_TICK, phase: PH_FIRST, bit_count: 4'd0,
                           shift_byte: 8'd0, delay_count: 16'd0, poll_count: 8'd0,
                           scl: 1'b1, drive: 1'b1, sda: 1'b1, ack_flag: 1'b0,
                           read_latch: 8'd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_busy_reg     <= (state_next.active_command != OP_TICK);
            out_done_reg     <= step_done;
            out_rejected_reg <= step_rejected;
        end
    end

    // Pin, data and ACK fields come straight from the committed sequencer state.
    assign res.valid     = out_valid_reg;
    assign res.scl_level = state_reg.scl;
    assign res.sda_drive = state_reg.drive;
    assign res.sda_level = state_reg.sda;
    assign res.busy_res  = out_busy_reg;
    assign res.done_res  = out_done_reg;
    assign res.read_data = state_reg.read_latch;
    assign res.ack_ok    = state_reg.ack_flag;
    assign res.rejected  = out_rejected_reg;

endmodule
